// ----- rtl/tlrq_pkg.sv -----
// shared types and codes for the three-level ready queue scheduler
// no dependencies; imported by every rtl module and the checker
`timescale 1ns / 1ps
`default_nettype none

package tlrq_pkg;

  // request kinds carried in tuser on the input side
  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // result status codes
  localparam int unsigned STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HIGH     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NORMAL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOW      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd5;

  // queue selectors, also the priority codes
  localparam logic [1:0] Q_HIGH   = 2'd0;
  localparam logic [1:0] Q_NORMAL = 2'd1;
  localparam logic [1:0] Q_LOW    = 2'd2;
  localparam int unsigned NUM_Q   = 3;

  // saturating normal-pass counter
  localparam int unsigned NS_W = 6;
  localparam logic [NS_W-1:0] NS_MAX = 6'd63;

  // one access to the shared queue memory
  typedef struct packed {
    logic       we;
    logic       re;
    logic [1:0] queue;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/tlrq_mem.sv -----
// shared storage for the three ready queues, one write or one read a cycle
// depends on tlrq_pkg for the request struct
`timescale 1ns / 1ps
`default_nettype none

module tlrq_mem
  import tlrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic               clk_i,
  input  mem_req_t           req_i,
  input  logic [PTR_W-1:0]   ptr_i,
  input  logic [ID_BITS-1:0] wdata_i,
  output logic [ID_BITS-1:0] rdata_o
);

  logic [ID_BITS-1:0] mem_q [NUM_Q][QUEUE_DEPTH];
  logic [ID_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.queue][ptr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.queue][ptr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/tlrq_ctrl.sv -----
// queue pointers, counts and the anti-starvation turn rule
// depends on tlrq_pkg; drives tlrq_mem
`timescale 1ns / 1ps
`default_nettype none

module tlrq_ctrl
  import tlrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                op_i,
  input  logic [ID_BITS-1:0]  id_i,
  input  logic [1:0]          prio_i,
  output mem_req_t            mem_req_o,
  output logic [PTR_W-1:0]    ptr_o,
  output logic [ID_BITS-1:0]  wdata_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = NS_W + CNT_W;

  logic [PTR_W-1:0] head_q [NUM_Q];
  logic [PTR_W-1:0] head_d [NUM_Q];
  logic [CNT_W-1:0] cnt_q  [NUM_Q];
  logic [CNT_W-1:0] cnt_d  [NUM_Q];
  logic             hi_turn_q, hi_turn_d;
  logic             norm_turn_q, norm_turn_d;
  logic [CNT_W-1:0] hs_q, hs_d;
  logic [NS_W-1:0]  ns_q, ns_d;

  logic [1:0]       sel;
  logic [1:0]       psel;
  logic             pop;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] hs_inc;
  logic [CNT_W-1:0] hc, nc, lc;
  mem_req_t         req;

  assign hc = cnt_q[Q_HIGH];
  assign nc = cnt_q[Q_NORMAL];
  assign lc = cnt_q[Q_LOW];

  // priority code three goes to low
  always_comb begin
    case (prio_i)
      Q_HIGH:   sel = Q_HIGH;
      Q_NORMAL: sel = Q_NORMAL;
      default:  sel = Q_LOW;
    endcase
  end

  assign tail_sum = SUM_W'(head_q[sel]) + SUM_W'(cnt_q[sel]);
  assign hs_inc   = SUM_W'(hs_q) + SUM_W'(1);

  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    hi_turn_d   = hi_turn_q;
    norm_turn_d = norm_turn_q;
    hs_d        = hs_q;
    ns_d        = ns_q;
    req         = '0;
    ptr_o       = '0;
    pop         = 1'b0;
    psel        = Q_HIGH;
    status_o    = ST_IDLE;

    if (op_i == OP_ENQUEUE) begin
      if (cnt_q[sel] == CNT_W'(QUEUE_DEPTH)) begin
        status_o = ST_FULL;
      end else begin
        status_o   = ST_ENQUEUED;
        req.we     = 1'b1;
        req.queue  = sel;
        ptr_o      = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                     ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
        cnt_d[sel] = cnt_q[sel] + CNT_W'(1);
      end
    end else begin
      if (hi_turn_q && hc != '0) begin
        pop      = 1'b1;
        psel     = Q_HIGH;
        status_o = ST_HIGH;
        hs_d     = CNT_W'(hs_inc);
        // end of a high pass hands the turn on
        if (hs_inc >= SUM_W'(hc)) begin
          hs_d      = '0;
          hi_turn_d = 1'b0;
          if (CMP_W'(ns_q) >= CMP_W'(nc)) begin
            ns_d        = '0;
            norm_turn_d = 1'b0;
          end else begin
            norm_turn_d = 1'b1;
          end
        end
      end else if (norm_turn_q && nc != '0) begin
        pop       = 1'b1;
        psel      = Q_NORMAL;
        status_o  = ST_NORMAL;
        hi_turn_d = 1'b1;
        if (ns_q != NS_MAX) begin
          ns_d = ns_q + NS_W'(1);
        end
      end else if (lc != '0) begin
        pop       = 1'b1;
        psel      = Q_LOW;
        status_o  = ST_LOW;
        hi_turn_d = 1'b1;
      end else if (hc != '0) begin
        pop      = 1'b1;
        psel     = Q_HIGH;
        status_o = ST_HIGH;
      end else if (nc != '0) begin
        pop      = 1'b1;
        psel     = Q_NORMAL;
        status_o = ST_NORMAL;
      end

      if (pop) begin
        req.re       = 1'b1;
        req.queue    = psel;
        ptr_o        = head_q[psel];
        head_d[psel] = (head_q[psel] == PTR_W'(QUEUE_DEPTH - 1))
                       ? '0 : head_q[psel] + PTR_W'(1);
        cnt_d[psel]  = cnt_q[psel] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_Q; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      hi_turn_q   <= 1'b1;
      norm_turn_q <= 1'b1;
      hs_q        <= '0;
      ns_q        <= '0;
    end else if (accept_i) begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      hi_turn_q   <= hi_turn_d;
      norm_turn_q <= norm_turn_d;
      hs_q        <= hs_d;
      ns_q        <= ns_d;
    end
  end

  assign mem_req_o.we    = req.we & accept_i;
  assign mem_req_o.re    = req.re & accept_i;
  assign mem_req_o.queue = req.queue;
  assign wdata_o         = id_i;

endmodule

`default_nettype wire

// ----- rtl/three_level_ready_queue_scheduler.sv -----
// three-level ready queue scheduler, top level with stream handshakes
// depends on tlrq_pkg, tlrq_ctrl and tlrq_mem
`timescale 1ns / 1ps
`default_nettype none

// Three FIFO ready queues (high, normal, low) of task IDs share one synchronous
// memory. Every request gives exactly one result. An enqueue (tuser 0) appends
// the ID to the queue of its priority, or answers "full" and changes nothing.
// A dispatch (tuser 1) pops one task under an anti-starvation turn rule: high
// is served for one pass over its count, then normal gets a turn, and after a
// pass over the normal count low goes next; if the rule finds nothing, the
// first nonempty queue is taken, and with all queues empty the idle status
// is returned with ID 0. The block takes one request per cycle unless a
// result waits behind a stalled output. A result passes the queue memory
// read, then the output register. Only pointers, counts, turn state and valid
// flags are reset; queue storage needs no clearing after reset.
module three_level_ready_queue_scheduler
  import tlrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // task_id [7:0], task_priority [9:8], zero
  input  logic                s_axis_tuser,  // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // granted_id [7:0]
  output logic [STATUS_W-1:0] m_axis_tuser   // status [2:0]
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  mem_req_t            mem_req;
  logic [PTR_W-1:0]    mem_ptr;
  logic [ID_BITS-1:0]  mem_wdata;
  logic [ID_BITS-1:0]  mem_rdata;
  logic [STATUS_W-1:0] status;
  logic                accept;
  logic                move;

  // request in flight waiting for its memory read
  logic                pend_q, pend_d;
  logic                pend_pop_q;
  logic [STATUS_W-1:0] pend_status_q;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_id_q;
  logic [STATUS_W-1:0] out_status_q;

  // the pending result moves out when the output register is free or drains
  assign move          = pend_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~pend_q | move;
  assign accept        = s_axis_tvalid & s_axis_tready;

  tlrq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (s_axis_tuser),
    .id_i      (ID_BITS'(s_axis_tdata[7:0])),
    .prio_i    (s_axis_tdata[9:8]),
    .mem_req_o (mem_req),
    .ptr_o     (mem_ptr),
    .wdata_o   (mem_wdata),
    .status_o  (status)
  );

  // read data stays put until the next pop, so a stalled result keeps it
  tlrq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .ptr_i   (mem_ptr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    pend_d = pend_q;
    if (move) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_pop_q    <= mem_req.re;
      pend_status_q <= status;
    end
    if (move) begin
      out_status_q <= pend_status_q;
      out_id_q     <= pend_pop_q ? 8'(mem_rdata) : 8'd0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/tlrq_checker.sv -----
// port-level checks for the scheduler, bound to the top level
// depends on tlrq_pkg for status codes
`timescale 1ns / 1ps
`default_nettype none

module tlrq_checker
  import tlrq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [7:0]          m_axis_tdata,
  input logic [STATUS_W-1:0] m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // status is always a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ST_IDLE)
    else $error("undefined status code");

  // only a dispatch from a queue carries an id
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ENQUEUED || m_axis_tuser == ST_FULL ||
                      m_axis_tuser == ST_IDLE) |-> m_axis_tdata == 8'd0)
    else $error("nonzero id on enqueue or idle");

  // a request in flight blocks at most until its result leaves
  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !m_axis_tvalid |=> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind three_level_ready_queue_scheduler tlrq_checker u_tlrq_checker (.*);

`default_nettype wire

// ----- verif/three_level_ready_queue_scheduler_test.sv -----
// self-checking testbench for the three-level ready queue scheduler
// depends on tlrq_pkg and the scheduler rtl; no files or arguments are read
`timescale 1ns / 1ps

module three_level_ready_queue_scheduler_test
  import tlrq_pkg::*;
;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned ID_BITS      = 8;
  localparam int unsigned RANDOM_ITEMS = 1125;
  // leave a margin after the last expected result when draining
  localparam int unsigned DRAIN_CYCLES = 8;
  // far above the slowest run: every request waits out gaps and output stalls
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // one scheduler answer as seen on the result stream
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          id;
  } grant_t;

  // one row of the directed table, repeated reps times with the id counting up
  typedef struct {
    logic       op;
    logic [7:0] id;
    logic [1:0] prio;
    int         reps;
    logic       typed;
    grant_t     exp;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;   // task_id [7:0], task_priority [9:8], zero
  logic                s_axis_tuser;   // op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // granted_id [7:0]
  logic [STATUS_W-1:0] m_axis_tuser;   // status [2:0]

  three_level_ready_queue_scheduler #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow copy of the scheduler state
  logic [7:0]      high_ready[$];
  logic [7:0]      normal_ready[$];
  logic [7:0]      low_ready[$];
  logic            hi_turn;
  logic            normal_turn;
  logic [4:0]      high_served;
  logic [NS_W-1:0] normal_served;

  // answers still owed by the block, oldest first
  grant_t expected_grants[$];

  // handshake between the posedge monitor and the negedge driver
  logic   req_taken;
  logic   cur_typed;
  grant_t cur_exp;

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;

  // work out the answer to one request and advance the shadow state
  function automatic grant_t predict_grant(input logic op, input logic [7:0] id,
                                           input logic [1:0] prio);
    grant_t g;
    int     hc;
    int     nc;
    g.status = ST_IDLE;
    g.id     = '0;
    hc       = high_ready.size();
    nc       = normal_ready.size();
    if (op == OP_ENQUEUE) begin
      // full queue drops the request and leaves the state alone
      g.status = ST_ENQUEUED;
      case (prio)
        Q_HIGH: begin
          if (hc < QUEUE_DEPTH) high_ready.push_back(id);
          else g.status = ST_FULL;
        end
        Q_NORMAL: begin
          if (nc < QUEUE_DEPTH) normal_ready.push_back(id);
          else g.status = ST_FULL;
        end
        default: begin
          // priority code three lands in the low queue too
          if (low_ready.size() < QUEUE_DEPTH) low_ready.push_back(id);
          else g.status = ST_FULL;
        end
      endcase
    end else if (hi_turn && hc != 0) begin
      g.status    = ST_HIGH;
      g.id        = high_ready.pop_front();
      high_served = high_served + 5'd1;
      // end of a high pass hands the turn on
      if (high_served >= hc) begin
        high_served = '0;
        hi_turn     = 1'b0;
        if (normal_served >= nc) begin
          normal_served = '0;
          normal_turn   = 1'b0;
        end else begin
          normal_turn = 1'b1;
        end
      end
    end else if (normal_turn && nc != 0) begin
      g.status  = ST_NORMAL;
      g.id      = normal_ready.pop_front();
      if (normal_served < NS_MAX) normal_served = normal_served + NS_W'(1);
      hi_turn   = 1'b1;
    end else if (low_ready.size() != 0) begin
      g.status  = ST_LOW;
      g.id      = low_ready.pop_front();
      hi_turn   = 1'b1;
    end else if (hc != 0) begin
      // fallback pops keep the turn state as it is
      g.status = ST_HIGH;
      g.id     = high_ready.pop_front();
    end else if (nc != 0) begin
      g.status = ST_NORMAL;
      g.id     = normal_ready.pop_front();
    end
    return g;
  endfunction

  // present one request from a falling edge on, return at the falling edge after
  // it was taken; the sender works in bursts with random gaps in between
  task automatic send_request(input logic op, input logic [7:0] id, input logic [1:0] prio,
                              input logic typed, input grant_t exp);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    cur_typed     = typed;
    cur_exp       = exp;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, prio, id};
    s_axis_tuser  <= op;
    do @(negedge clk_i); while (!req_taken);
    req_taken = 1'b0;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // monitor: predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin : monitor
    grant_t g;
    grant_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        g = predict_grant(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[9:8]);
        // rows with a typed answer are held to that answer
        expected_grants.push_back(cur_typed ? cur_exp : g);
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result: status %0d granted_id %0d", m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata !== want.id) begin
            $error("granted_id: expected %0d, actual %0d", want.id, m_axis_tdata);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: switches between always ready, coin flips, rare ready and a
  // repeating bit pattern, each for a random stretch
  initial begin : rx_stall
    int unsigned    mode;
    int unsigned    mode_left;
    logic [7:0]     pattern;
    m_axis_tready = 1'b0;
    mode_left     = 0;
    mode          = 0;
    pattern       = 8'hff;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
        pattern   = 8'($urandom_range(1, 255));
      end
      mode_left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          m_axis_tready <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
      endcase
    end
  end

  // sender: reset, directed table, random phases, drain, verdict
  initial begin : stimulus
    dir_row_t    rows[$];
    dir_row_t    row;
    grant_t      none;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned mode;
    int unsigned dispatch_pct;
    int unsigned pick;
    logic        op;
    logic [7:0]  id;
    logic [1:0]  prio;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ENQUEUE;
    req_taken     = 1'b0;
    cur_typed     = 1'b0;
    cur_exp       = '0;
    fail_count    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    hi_turn       = 1'b1;
    normal_turn   = 1'b1;
    high_served   = '0;
    normal_served = '0;
    none          = '0;

    // directed rows: op, first id, priority, repeats, typed, expected answer
    // dispatch with nothing queued gives the idle answer
    rows.push_back('{OP_DISPATCH, 8'h00, Q_HIGH,   1,  1'b1, '{ST_IDLE,     8'h00}});
    // task id zero, the top id, and priority code three in the low queue
    rows.push_back('{OP_ENQUEUE,  8'h00, Q_HIGH,   1,  1'b1, '{ST_ENQUEUED, 8'h00}});
    rows.push_back('{OP_ENQUEUE,  8'hff, Q_NORMAL, 1,  1'b1, '{ST_ENQUEUED, 8'h00}});
    rows.push_back('{OP_ENQUEUE,  8'ha5, Q_LOW,    1,  1'b1, '{ST_ENQUEUED, 8'h00}});
    rows.push_back('{OP_ENQUEUE,  8'h5a, 2'd3,     1,  1'b1, '{ST_ENQUEUED, 8'h00}});
    // turn rule drains the four, then idle again
    rows.push_back('{OP_DISPATCH, 8'h00, Q_HIGH,   4,  1'b0, '{ST_IDLE,     8'h00}});
    rows.push_back('{OP_DISPATCH, 8'h3c, Q_LOW,    1,  1'b1, '{ST_IDLE,     8'h00}});
    // fill the high queue to the brim, then one more is rejected
    rows.push_back('{OP_ENQUEUE,  8'h80, Q_HIGH,   16, 1'b1, '{ST_ENQUEUED, 8'h00}});
    rows.push_back('{OP_ENQUEUE,  8'h7f, Q_HIGH,   1,  1'b1, '{ST_FULL,     8'h00}});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[r]) begin
      row = rows[r];
      for (int k = 0; k < row.reps; k++) begin
        send_request(row.op, row.id + 8'(k), row.prio, row.typed, row.exp);
      end
    end

    // random phases, each with its own dispatch share and priority mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len    = $urandom_range(20, 140);
      mode         = $urandom_range(0, 3);
      dispatch_pct = $urandom_range(15, 85);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        op   = ($urandom_range(0, 99) < dispatch_pct) ? OP_DISPATCH : OP_ENQUEUE;
        id   = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        case (mode)
          0: prio = 2'($urandom_range(0, 3));
          // high heavy
          1: prio = (pick < 70) ? Q_HIGH : 2'($urandom_range(1, 3));
          // no high at all, so the normal counter can climb to saturation
          2: prio = (pick < 85) ? Q_NORMAL : 2'($urandom_range(2, 3));
          default: prio = (pick < 60) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
        endcase
        send_request(op, id, prio, 1'b0, none);
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
